@@ hdl/jsu_pkg.sv @@
package jsu_pkg;

    localparam int unsigned MaxRes = 3;
    localparam int unsigned ByteW  = 8;

    typedef enum logic [1:0] {
        ST_BYTE = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    // Results caused by one source byte, oldest in entry 0.
    typedef struct packed {
        logic [1:0]                      n;
        t_status                         status;
        logic [MaxRes-1:0][ByteW-1:0]    bytes;
    } t_step;

    // One buffered result beat.
    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        t_status          status;
        logic             last;
    } t_res;

endpackage

@@ hdl/jsu_if.sv @@
interface jsu_in_if import jsu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] in_byte;
    logic             start_req;

    modport source (output valid, output in_byte, output start_req, input ready);
    modport sink   (input valid, input in_byte, input start_req, output ready);
endinterface

interface jsu_out_if import jsu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] out_byte;
    logic [1:0]       status;
    logic             last_of_run;

    modport source (output valid, output out_byte, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input last_of_run,
                    output ready);
endinterface

@@ hdl/jsu_parse.sv @@
module jsu_parse import jsu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [ByteW-1:0] i_byte,
    input  logic             i_start,
    output t_step            o_step
);

    typedef enum logic [2:0] {
        PH_DONE = 3'd0,
        PH_WS   = 3'd1,
        PH_BODY = 3'd2,
        PH_ESC  = 3'd3,
        PH_HEX  = 3'd4
    } t_phase;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_A  = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] VAL_BS   = 8'h08;
    localparam logic [7:0] VAL_FF   = 8'h0C;

    localparam logic [15:0] Lim1 = 16'h0080;
    localparam logic [15:0] Lim2 = 16'h0800;
    localparam logic [7:0]  Lead2 = 8'd192;
    localparam logic [7:0]  Lead3 = 8'd224;
    localparam logic [7:0]  Cont  = 8'd128;

    t_phase      r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;

    t_phase      ph;
    logic [15:0] acc;
    logic [1:0]  cnt;
    logic [15:0] cp;
    logic [3:0]  dig;
    logic        dig_ok;

    always_comb begin
        dig_ok = 1'b1;
        dig    = 4'd0;
        if (i_byte inside {[CH_0:CH_9]}) begin
            dig = 4'(i_byte - CH_0);
        end else if (i_byte inside {[CH_LA:CH_LF_A]}) begin
            dig = 4'(i_byte - CH_LA + 8'd10);
        end else if (i_byte inside {[CH_UA:CH_UF]}) begin
            dig = 4'(i_byte - CH_UA + 8'd10);
        end else begin
            dig_ok = 1'b0;
        end
    end

    always_comb begin
        ph  = i_start ? PH_WS : r_phase;
        acc = i_start ? 16'd0 : r_acc;
        cnt = i_start ? 2'd0 : r_cnt;
        cp  = {acc[11:0], dig};

        n_phase = ph;
        n_acc   = acc;
        n_cnt   = cnt;
        o_step  = '0;
        o_step.status = ST_BYTE;

        case (ph)
            PH_WS: begin
                if (i_byte == CH_QUOTE) begin
                    n_phase = PH_BODY;
                end else if (!(i_byte inside {CH_TAB, CH_LF, CH_CR, CH_SP})) begin
                    n_phase       = PH_DONE;
                    o_step.n      = 2'd1;
                    o_step.status = ST_ERR;
                end
            end
            PH_BODY: begin
                if (i_byte == CH_NUL) begin
                    n_phase       = PH_DONE;
                    o_step.n      = 2'd1;
                    o_step.status = ST_ERR;
                end else if (i_byte == CH_QUOTE) begin
                    n_phase       = PH_DONE;
                    o_step.n      = 2'd1;
                    o_step.status = ST_DONE;
                end else if (i_byte == CH_BSL) begin
                    n_phase = PH_ESC;
                end else begin
                    o_step.n        = 2'd1;
                    o_step.bytes[0] = i_byte;
                end
            end
            PH_ESC: begin
                n_phase  = PH_BODY;
                o_step.n = 2'd1;
                case (i_byte)
                    CH_QUOTE, CH_BSL, CH_SLASH: o_step.bytes[0] = i_byte;
                    CH_B: o_step.bytes[0] = VAL_BS;
                    CH_F: o_step.bytes[0] = VAL_FF;
                    CH_N: o_step.bytes[0] = CH_LF;
                    CH_R: o_step.bytes[0] = CH_CR;
                    CH_T: o_step.bytes[0] = CH_TAB;
                    CH_U: begin
                        n_phase  = PH_HEX;
                        n_acc    = 16'd0;
                        n_cnt    = 2'd0;
                        o_step.n = 2'd0;
                    end
                    default: begin
                        n_phase       = PH_DONE;
                        o_step.status = ST_ERR;
                    end
                endcase
            end
            PH_HEX: begin
                if (!dig_ok) begin
                    n_phase       = PH_DONE;
                    o_step.n      = 2'd1;
                    o_step.status = ST_ERR;
                end else begin
                    n_acc = cp;
                    if (cnt != 2'd3) begin
                        n_cnt = cnt + 2'd1;
                    end else begin
                        n_cnt   = 2'd0;
                        n_phase = PH_BODY;
                        if (cp < Lim1) begin
                            o_step.n        = 2'd1;
                            o_step.bytes[0] = cp[7:0];
                        end else if (cp < Lim2) begin
                            o_step.n        = 2'd2;
                            o_step.bytes[0] = Lead2 | {3'd0, cp[10:6]};
                            o_step.bytes[1] = Cont | {2'd0, cp[5:0]};
                        end else begin
                            o_step.n        = 2'd3;
                            o_step.bytes[0] = Lead3 | {4'd0, cp[15:12]};
                            o_step.bytes[1] = Cont | {2'd0, cp[11:6]};
                            o_step.bytes[2] = Cont | {2'd0, cp[5:0]};
                        end
                    end
                end
            end
            default: begin
                // Finished or an unused code: the byte is dropped.
                n_phase = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_acc   <= 16'd0;
            r_cnt   <= 2'd0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ hdl/json_string_unescape_utf8_top.sv @@
// Source bytes pass through the input register into the parser, whose results load the
// result buffer. Throughput: one byte per cycle when the output is ready; a \u escape
// with two or three UTF-8 bytes holds the input while the three-entry result buffer drains.
// Reset (synchronous, active low): the result buffer and input register empty, and the
// parser finished, so bytes give no result until one arrives with a start request.
module json_string_unescape_utf8_top import jsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_start;

    t_res       r_ob [MaxRes];
    logic [1:0] r_rem;

    t_step step;
    logic  out_fire;
    logic  can_load;
    logic  proc;
    logic  in_ready;

    jsu_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .o_step  (step)
    );

    assign out_fire = o_out.valid && o_out.ready;
    // New results may be loaded once the buffer is empty after this cycle's beat.
    assign can_load = (r_rem == 2'd0) || ((r_rem == 2'd1) && o_out.ready);
    assign proc     = r_in_valid && ((step.n == 2'd0) || can_load);
    assign in_ready = !r_in_valid || proc;

    assign i_in.ready        = in_ready;
    assign o_out.valid       = (r_rem != 2'd0);
    assign o_out.out_byte    = r_ob[0].out_byte;
    assign o_out.status      = r_ob[0].status;
    assign o_out.last_of_run = r_ob[0].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_byte  <= i_in.in_byte;
            r_in_start <= i_in.start_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 2'd0;
        end else if (proc && (step.n != 2'd0)) begin
            r_rem <= step.n;
        end else if (out_fire) begin
            r_rem <= r_rem - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && (step.n != 2'd0)) begin
            for (int k = 0; k < MaxRes; k++) begin
                r_ob[k].out_byte <= step.bytes[k];
                r_ob[k].status   <= step.status;
                r_ob[k].last     <= (2'(k + 1) == step.n);
            end
        end else if (out_fire) begin
            for (int k = 0; k < MaxRes - 1; k++) begin
                r_ob[k] <= r_ob[k + 1];
            end
        end
    end

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (step.n != 2'd0) |=> o_out.valid)
        else $error("loaded results not presented");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (r_rem > 2'd1) |-> !o_out.last_of_run)
        else $error("last flag before the final beat of a run");

    a_term_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status != ST_BYTE)
            |-> o_out.last_of_run && (o_out.out_byte == 8'd0))
        else $error("completion or error beat malformed");

endmodule
